/* hw/rtl/rtc_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the resp command tokenizer
// no dependencies
package rtc_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CHR_STAR   = 8'h2A;
	localparam logic [7:0] CHR_DOLLAR = 8'h24;
	localparam logic [7:0] CHR_CR     = 8'h0D;
	localparam logic [7:0] CHR_LF     = 8'h0A;
	localparam logic [7:0] CHR_PLUS   = 8'h2B;
	localparam logic [7:0] CHR_MINUS  = 8'h2D;
	localparam logic [7:0] CHR_SPACE  = 8'h20;
	localparam logic [7:0] CHR_TAB    = 8'h09;
	localparam logic [7:0] CHR_ZERO   = 8'h30;
	localparam logic [7:0] CHR_NINE   = 8'h39;
	localparam logic [1:0] SKIP_BYTES = 2'd2;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_TEND = 2'd1,
		KIND_MEND = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FORMAT = 2'd1,
		ST_TRUNC  = 2'd2
	} status_t;

	// the results one input item causes, always in this order
	typedef struct packed {
		logic       has_byte;
		logic [7:0] tbyte;
		logic       has_tend;
		logic       has_mend;
		status_t    status;
	} bundle_t;

	typedef struct packed {
		logic    valid;
		bundle_t data;
	} push_t;

	typedef struct packed {
		logic    empty;
		bundle_t data;
	} head_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == CHR_SPACE) || (b >= CHR_TAB && b <= CHR_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CHR_ZERO) && (b <= CHR_NINE);
	endfunction

endpackage

/* hw/rtl/rtc_channels_if.sv */
`timescale 1ns / 1ps
// valid/ready channels for command bytes and tokenizer results
// depends on rtc_pkg
interface rtc_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       message_end;

	modport source(output valid, data_byte, byte_present, message_end, input ready);
	modport sink(input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface rtc_tok_if;
	logic            valid;
	logic            ready;
	rtc_pkg::kind_t   kind;
	logic [7:0]      token_byte;
	rtc_pkg::status_t status;
	logic            last_of_run;

	modport source(output valid, kind, token_byte, status, last_of_run, input ready);
	modport sink(input valid, kind, token_byte, status, last_of_run, output ready);
endinterface

/* hw/rtl/resp_command_tokenizer.sv */
`timescale 1ns / 1ps
// top level of the resp command tokenizer: front parser, bundle queue, back unpacker
// depends on rtc_pkg, rtc_channels_if, rtc_front, rtc_queue, rtc_back
//
//  channel  dir  payload                                       per transfer
//  cmd      in   data_byte, byte_present, message_end          one line byte or end
//  tok      out  kind, token_byte, status, last_of_run         one result
//
// the front parser takes one item a cycle while the queue is not full, its state
// updated in the same cycle; each result leaves through the output register; an
// item with two or three results holds the back end, a four-entry queue absorbs this
// reset clears parser state, queue pointers and output valid at once
// a stall on tok fills the queue and then drops cmd.ready
module resp_command_tokenizer #(
	parameter int NUMBER_BITS = 31
) (
	input  logic      clk,
	input  logic      arst_n,
	rtc_cmd_if.sink   cmd,
	rtc_tok_if.source tok
);
	import rtc_pkg::*;

	push_t push;
	head_t head;
	logic  q_full;
	logic  pop;

	rtc_front #(
		.NUMBER_BITS(NUMBER_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.push  (push),
		.q_full(q_full)
	);

	rtc_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (q_full),
		.pop   (pop),
		.head  (head)
	);

	rtc_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.pop   (pop),
		.tok   (tok)
	);

endmodule

/* hw/rtl/rtc_front.sv */
`timescale 1ns / 1ps
// front end: takes one command byte a cycle unless the queue is full, parses resp
// or whitespace form, pushes its results as one bundle; depends on rtc_pkg, rtc_cmd_if
module rtc_front #(
	parameter int NUMBER_BITS = 31
) (
	input  logic           clk,
	input  logic           arst_n,
	rtc_cmd_if.sink        cmd,
	output rtc_pkg::push_t push,
	input  logic           q_full
);
	import rtc_pkg::*;

	localparam int NB = NUMBER_BITS;
	localparam int WB = NUMBER_BITS + 4;

	typedef enum logic [1:0] {MODE_WAIT, MODE_WS, MODE_RESP} mode_t;
	typedef enum logic [2:0] {
		PH_CNT_NUM, PH_CNT_LF, PH_DOLLAR, PH_LEN_NUM,
		PH_LEN_LF, PH_PAYLOAD, PH_SKIP, PH_DONE
	} phase_t;

	mode_t           mode_q, n_mode;
	phase_t          phase_q, n_phase;
	logic [NB-1:0]   acc_q, n_acc;
	logic [NB-1:0]   elems_q, n_elems;
	logic [NB-1:0]   bytes_q, n_bytes;
	logic [1:0]      skip_q, n_skip;
	logic            digit_q, n_digit;
	logic            sign_q, n_sign;
	logic            neg_q, n_neg;
	logic            tail_q, n_tail;
	logic            word_q, n_word;
	logic            err_q, n_err;

	logic            take;
	logic            drop_b;
	logic [7:0]      b;
	logic [WB-1:0]   wide;
	logic [WB-1:0]   v;
	logic [NB-1:0]   el_dec;
	logic [NB-1:0]   bl_dec;
	logic [1:0]      sk_dec;
	bundle_t         bun;

	assign cmd.ready = !q_full;
	assign take      = cmd.valid && cmd.ready;
	assign b         = cmd.data_byte;
	assign wide      = WB'(acc_q);
	assign v         = (wide << 3) + (wide << 1) + WB'(b[3:0]);
	assign el_dec    = (elems_q != '0) ? elems_q - NB'(1) : '0;
	assign bl_dec    = (bytes_q != '0) ? bytes_q - NB'(1) : '0;
	assign sk_dec    = (skip_q != 2'd0) ? skip_q - 2'd1 : 2'd0;

	always_comb begin
		n_mode  = mode_q;
		n_phase = phase_q;
		n_acc   = acc_q;
		n_elems = elems_q;
		n_bytes = bytes_q;
		n_skip  = skip_q;
		n_digit = digit_q;
		n_sign  = sign_q;
		n_neg   = neg_q;
		n_tail  = tail_q;
		n_word  = word_q;
		n_err   = err_q;
		drop_b  = 1'b0;
		bun     = '{has_byte: 1'b0, tbyte: 8'd0, has_tend: 1'b0, has_mend: 1'b0,
			status: ST_OK};

		if (cmd.byte_present) begin
			if (mode_q == MODE_WAIT) begin
				if (b == CHR_STAR) begin
					n_mode  = MODE_RESP;
					n_phase = PH_CNT_NUM;
					drop_b  = 1'b1;
				end else begin
					n_mode = MODE_WS;
				end
			end
			if (!drop_b) begin
				if (n_mode == MODE_WS) begin
					if (is_space(b)) begin
						if (word_q) begin
							bun.has_tend = 1'b1;
							n_word       = 1'b0;
						end
					end else begin
						bun.has_byte = 1'b1;
						bun.tbyte    = b;
						n_word       = 1'b1;
					end
				end else if (!err_q) begin
					case (phase_q)
						PH_CNT_NUM, PH_LEN_NUM: begin
							if (b == CHR_CR) begin
								n_phase = phase_t'(phase_q + 3'd1);
							end else if (!digit_q) begin
								if (is_digit(b)) begin
									n_acc   = NB'(b[3:0]);
									n_digit = 1'b1;
								end else if (!sign_q && is_space(b)) begin
									n_acc = acc_q;
								end else if (!sign_q && (b == CHR_PLUS || b == CHR_MINUS)) begin
									n_sign = 1'b1;
									n_neg  = (b == CHR_MINUS);
								end else begin
									n_err = 1'b1;
								end
							end else if (!tail_q) begin
								if (is_digit(b)) begin
									if (v[WB-1:NB] != '0)
										n_err = 1'b1;
									else
										n_acc = v[NB-1:0];
								end else begin
									n_tail = 1'b1;
								end
							end
						end
						PH_CNT_LF: begin
							if (b != CHR_LF || !digit_q) begin
								n_err = 1'b1;
							end else begin
								if (neg_q || acc_q == '0) begin
									n_phase = PH_DONE;
								end else begin
									n_elems = acc_q;
									n_phase = PH_DOLLAR;
								end
								n_acc   = '0;
								n_digit = 1'b0;
								n_sign  = 1'b0;
								n_neg   = 1'b0;
								n_tail  = 1'b0;
							end
						end
						PH_LEN_LF: begin
							if (b != CHR_LF || !digit_q || (neg_q && acc_q != '0)) begin
								n_err = 1'b1;
							end else begin
								n_bytes = acc_q;
								if (acc_q == '0) begin
									bun.has_tend = 1'b1;
									n_elems      = el_dec;
									if (el_dec == '0) begin
										n_phase = PH_DONE;
									end else begin
										n_skip  = SKIP_BYTES;
										n_phase = PH_SKIP;
									end
								end else begin
									n_phase = PH_PAYLOAD;
								end
								n_acc   = '0;
								n_digit = 1'b0;
								n_sign  = 1'b0;
								n_neg   = 1'b0;
								n_tail  = 1'b0;
							end
						end
						PH_DOLLAR: begin
							if (b == CHR_DOLLAR)
								n_phase = PH_LEN_NUM;
							else
								n_err = 1'b1;
						end
						PH_PAYLOAD: begin
							bun.has_byte = 1'b1;
							bun.tbyte    = b;
							n_bytes      = bl_dec;
							if (bl_dec == '0) begin
								bun.has_tend = 1'b1;
								n_elems      = el_dec;
								if (el_dec == '0) begin
									n_phase = PH_DONE;
								end else begin
									n_skip  = SKIP_BYTES;
									n_phase = PH_SKIP;
								end
							end
						end
						PH_SKIP: begin
							n_skip = sk_dec;
							if (sk_dec == 2'd0)
								n_phase = (elems_q != '0) ? PH_DOLLAR : PH_DONE;
						end
						default: begin
							n_phase = phase_q;
						end
					endcase
				end
			end
		end

		if (cmd.message_end) begin
			bun.has_mend = 1'b1;
			if (n_mode == MODE_WS) begin
				if (n_word)
					bun.has_tend = 1'b1;
			end else if (n_mode == MODE_RESP) begin
				if (n_err || n_phase <= PH_LEN_LF)
					bun.status = ST_FORMAT;
				else if (n_phase == PH_PAYLOAD)
					bun.status = ST_TRUNC;
			end
			n_mode  = MODE_WAIT;
			n_phase = PH_CNT_NUM;
			n_acc   = '0;
			n_elems = '0;
			n_bytes = '0;
			n_skip  = 2'd0;
			n_digit = 1'b0;
			n_sign  = 1'b0;
			n_neg   = 1'b0;
			n_tail  = 1'b0;
			n_word  = 1'b0;
			n_err   = 1'b0;
		end
	end

	assign push.valid = take && (bun.has_byte || bun.has_tend || bun.has_mend);
	assign push.data  = bun;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_WAIT;
			phase_q <= PH_CNT_NUM;
			acc_q   <= '0;
			elems_q <= '0;
			bytes_q <= '0;
			skip_q  <= 2'd0;
			digit_q <= 1'b0;
			sign_q  <= 1'b0;
			neg_q   <= 1'b0;
			tail_q  <= 1'b0;
			word_q  <= 1'b0;
			err_q   <= 1'b0;
		end else if (take) begin
			mode_q  <= n_mode;
			phase_q <= n_phase;
			acc_q   <= n_acc;
			elems_q <= n_elems;
			bytes_q <= n_bytes;
			skip_q  <= n_skip;
			digit_q <= n_digit;
			sign_q  <= n_sign;
			neg_q   <= n_neg;
			tail_q  <= n_tail;
			word_q  <= n_word;
			err_q   <= n_err;
		end
	end

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		take && cmd.message_end |=> mode_q == MODE_WAIT && !err_q && !word_q)
		else $error("state not cleared after message end");

	a_err_resp_only: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> mode_q == MODE_RESP)
		else $error("error flag outside resp mode");

	a_word_ws_only: assert property (@(posedge clk) disable iff (!arst_n)
		word_q |-> mode_q == MODE_WS)
		else $error("open word outside whitespace mode");

endmodule

/* hw/rtl/rtc_queue.sv */
`timescale 1ns / 1ps
// short bundle queue between front and back end
// depends on rtc_pkg
module rtc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  rtc_pkg::push_t push,
	output logic           full,
	input  logic           pop,
	output rtc_pkg::head_t head
);
	import rtc_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	bundle_t       mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_pop;

	assign full       = (cnt_q == CW'(QUEUE_DEPTH));
	assign head.empty = (cnt_q == '0);
	assign head.data  = mem_q[rd_q];
	assign do_pop     = pop && !head.empty;

	always_ff @(posedge clk) begin
		if (push.valid)
			mem_q[wr_q] <= push.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid)
				wr_q <= wr_q + PW'(1);
			if (do_pop)
				rd_q <= rd_q + PW'(1);
			if (push.valid && !do_pop)
				cnt_q <= cnt_q + CW'(1);
			else if (!push.valid && do_pop)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.valid && full))
		else $error("push into full queue");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && head.empty))
		else $error("pop from empty queue");

endmodule

/* hw/rtl/rtc_back.sv */
`timescale 1ns / 1ps
// back end: unpacks each bundle into single results behind an output register
// depends on rtc_pkg, rtc_tok_if
module rtc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  rtc_pkg::head_t head,
	output logic           pop,
	rtc_tok_if.source      tok
);
	import rtc_pkg::*;

	logic       out_valid_q;
	kind_t      kind_q;
	logic [7:0] byte_q;
	status_t    status_q;
	logic       last_q;
	logic       sent_byte_q;
	logic       sent_tend_q;

	logic       load;
	logic       rem_byte;
	logic       rem_tend;
	kind_t      n_kind;
	logic       n_last;

	assign load     = (!out_valid_q || tok.ready) && !head.empty;
	assign rem_byte = head.data.has_byte && !sent_byte_q;
	assign rem_tend = head.data.has_tend && !sent_tend_q;

	always_comb begin
		if (rem_byte) begin
			n_kind = KIND_BYTE;
			n_last = !(head.data.has_tend || head.data.has_mend);
		end else if (rem_tend) begin
			n_kind = KIND_TEND;
			n_last = !head.data.has_mend;
		end else begin
			n_kind = KIND_MEND;
			n_last = 1'b1;
		end
	end

	assign pop = load && n_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sent_byte_q <= 1'b0;
			sent_tend_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			if (n_last) begin
				sent_byte_q <= 1'b0;
				sent_tend_q <= 1'b0;
			end else if (rem_byte) begin
				sent_byte_q <= 1'b1;
			end else begin
				sent_tend_q <= 1'b1;
			end
		end else if (tok.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= n_kind;
			byte_q   <= (n_kind == KIND_BYTE) ? head.data.tbyte : 8'd0;
			status_q <= (n_kind == KIND_MEND) ? head.data.status : ST_OK;
			last_q   <= n_last;
		end
	end

	assign tok.valid       = out_valid_q;
	assign tok.kind        = kind_q;
	assign tok.token_byte  = byte_q;
	assign tok.status      = status_q;
	assign tok.last_of_run = last_q;

	a_mend_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_MEND |-> last_q)
		else $error("message end not last of its run");

	a_partial_keeps_head: assert property (@(posedge clk) disable iff (!arst_n)
		load && !n_last |=> !head.empty && (sent_byte_q || sent_tend_q))
		else $error("bundle lost before all results sent");

	a_sent_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		(sent_byte_q || sent_tend_q) |-> !head.empty)
		else $error("partial bundle without queue head");

endmodule
